// ===== hw/rtl/bpo_pkg.sv =====
// ----------------------------------------------------------------------------
// bpo_pkg
// Types, register indexes and fixed-point helpers for the pulse oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpo_pkg;

    typedef struct packed {
        logic               kind;
        logic [11:0]        table_index;
        logic signed [15:0] table_value;
    } t_bpo_in;

    typedef struct packed {
        logic signed [31:0] sample;
    } t_bpo_out;

    typedef enum logic [2:0] {
        REG_PHASE_INC  = 3'd0,
        REG_AMPLITUDE  = 3'd1,
        REG_HARM_COUNT = 3'd2,
        REG_LOWEST     = 3'd3,
        REG_RATIO      = 3'd4,
        REG_START      = 3'd5
    } t_reg_idx;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic signed [31:0] Q24_ONE   = 32'sh0100_0000;
    localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;
    localparam logic [35:0]        DEN_SMALL = 36'd13422;

    // magnitude product -> round half away, clamp, apply sign, saturate
    function automatic logic signed [31:0] f_rsat(input logic [79:0] mag,
                                                  input logic [4:0]  sh,
                                                  input logic        neg);
        logic [79:0] p;
        p = (mag + (80'd1 << (sh - 5'd1))) >> sh;
        if (p > 80'h8000_0000) begin
            p = 80'h8000_0000;
        end
        if (neg) begin
            return 32'(32'd0 - p[31:0]);
        end else if (p == 80'h8000_0000) begin
            return S32_MAX;
        end else begin
            return p[31:0];
        end
    endfunction

    // signed quotient from magnitude and sign, saturated to 32 bits
    function automatic logic signed [31:0] f_qsat(input logic [63:0] q,
                                                  input logic        neg);
        if (neg) begin
            if (q > 64'h8000_0000) begin
                return S32_MIN;
            end
            return 32'(32'd0 - q[31:0]);
        end
        if (q > 64'h7FFF_FFFF) begin
            return S32_MAX;
        end
        return q[31:0];
    endfunction

    function automatic logic [32:0] f_abs33(input logic signed [32:0] v);
        return v[32] ? 33'(33'd0 - v) : v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bpo_stream_if.sv =====
// ----------------------------------------------------------------------------
// bpo_stream_if
// Valid/ready stream channel carrying one request payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpo_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bandlimited_pulse_oscillator_core.sv =====
// ----------------------------------------------------------------------------
// bandlimited_pulse_oscillator_core
// Closed-form sum of cosine harmonics from a cosine table in block memory.
//
//  channel  dir  payload                            request
//  i_in     in   kind, table_index, table_value     write word or tick
//  o_out    out  sample (Q8.24)                     one per tick
//  i_cfg_*  in   register index, data               register write
//
//  A tick is dominated by the serial divider plus five table reads through
//  the single memory port. After a ratio or count write the next tick also
//  recomputes the coefficients first (power by squaring on the shared
//  multiplier, then a second divide). Reset is synchronous; the table is
//  not cleared. A finished sample waits in the output register while the
//  core returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bandlimited_pulse_oscillator_core
    import bpo_pkg::*;
#(
    parameter int TABLE_DEPTH   = 4096,
    parameter int PHASE_BITS    = 24,
    parameter int MAX_HARMONICS = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bpo_stream_if.sink       i_in,
    bpo_stream_if.source     o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);

    localparam int TB = $clog2(TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_PW, S_PW_A, S_PW_X, S_PW_XR, S_NRM, S_NRM_D, S_RD,
        S_M1R, S_M2R, S_M3R, S_M4R, S_M5R, S_M6R, S_CHK, S_HOLD,
        S_Q, S_SC, S_QL, S_QH, S_QR, S_FIN, S_MWAIT, S_DIV
    } t_state;

    t_state r_state, r_ret;

    logic [23:0]           r_inc;
    logic [15:0]           r_amp;
    logic [7:0]            r_hc;
    logic signed [8:0]     r_low;
    logic signed [15:0]    r_ratio;
    logic [PHASE_BITS-1:0] r_acc_ph;
    logic signed [31:0]    r_prev, r_rpow, r_norm;
    logic                  r_coef_valid;

    logic signed [31:0] r_ans, r_x, r_scal, r_res;
    logic [7:0]         r_e;
    logic signed [35:0] r_den;
    logic signed [49:0] r_num;
    logic [63:0]        r_qmag;
    logic               r_qneg;
    logic [79:0]        r_acc;

    logic signed [32:0] r_ma, r_mb;
    logic signed [65:0] r_prod;
    logic               r_mneg;

    logic [35:0] r_rem, r_dvs;
    logic [63:0] r_dvd, r_quo;
    logic        r_dneg;
    logic [5:0]  r_dcnt;

    logic [2:0]         r_ti;
    logic signed [15:0] r_tv [5];
    logic [15:0]        mem [TABLE_DEPTH];
    logic [15:0]        r_rdata;

    logic               r_out_valid;
    logic signed [31:0] r_sample;

    // effective harmonic count
    logic [15:0] w_n16;
    logic [7:0]  w_n;
    always_comb begin
        w_n16 = (r_hc == 8'd0) ? 16'd1 : 16'(r_hc);
        if (w_n16 > 16'(MAX_HARMONICS)) begin
            w_n16 = 16'(MAX_HARMONICS);
        end
        w_n = w_n16[7:0];
    end

    // table addressing
    logic [TB-1:0]   w_phs, w_msel, w_rd_addr, w_wr_addr;
    logic [15:0]     w_k16, w_km1, w_kpn, w_kpnm1, w_idx16;
    logic [2*TB-1:0] w_amul;
    logic            w_rd_en, w_wr_en, w_in_acc;
    always_comb begin
        w_phs   = r_acc_ph[PHASE_BITS-1 -: TB];
        w_k16   = 16'(r_low);
        w_km1   = 16'(w_k16 - 16'd1);
        w_kpn   = 16'(w_k16 + 16'(w_n));
        w_kpnm1 = 16'(w_kpn - 16'd1);
        w_msel  = TB'(16'd1);
        case (r_ti)
            3'd1:    w_msel = w_k16[TB-1:0];
            3'd2:    w_msel = w_km1[TB-1:0];
            3'd3:    w_msel = w_kpn[TB-1:0];
            3'd4:    w_msel = w_kpnm1[TB-1:0];
            default: w_msel = TB'(16'd1);
        endcase
        w_amul    = w_phs * w_msel;
        w_rd_addr = w_amul[TB-1:0];
        w_idx16   = 16'(i_in.payload.table_index);
        w_wr_addr = w_idx16[TB-1:0];
    end

    assign i_in.ready = i_rst_n && (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_wr_en    = w_in_acc && (i_in.payload.kind == KIND_WRITE);
    assign w_rd_en    = (r_state == S_RD) && (r_ti < 3'd5);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= i_in.payload.table_value;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    // shared multiplier, one register stage
    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    logic signed [31:0] w_rs12, w_rs15, w_rs24, w_rsacc;
    assign w_rs12  = f_rsat(80'(r_prod), 5'd12, r_mneg);
    assign w_rs15  = f_rsat(80'(r_prod), 5'd15, r_mneg);
    assign w_rs24  = f_rsat(80'(r_prod), 5'd24, r_mneg);
    assign w_rsacc = f_rsat(r_acc, 5'd24, r_mneg);

    // divider step
    logic [36:0] w_rsh;
    logic        w_ge;
    assign w_rsh = {r_rem, r_dvd[63]};
    assign w_ge  = (w_rsh >= {1'b0, r_dvs});

    // recompute helpers
    logic [16:0]        w_absr;
    logic signed [32:0] w_nden;
    logic signed [17:0] w_nnum;
    logic [17:0]        w_nnum_mag;
    logic               w_near;
    logic [35:0]        w_den_mag;
    logic [49:0]        w_num_mag;
    always_comb begin
        w_absr     = r_ratio[15] ? 17'(17'd0 - 17'(r_ratio)) : 17'(r_ratio);
        w_nden     = 33'sh100_0000 - 33'(f_abs33(33'(r_ans)));
        w_nnum     = 18'sd4096 - 18'(w_absr);
        w_nnum_mag = w_nnum[17] ? 18'(18'd0 - w_nnum) : w_nnum;
        w_near     = (w_absr >= 17'd4092) && (w_absr <= 17'd4100);
        w_den_mag  = r_den[35] ? 36'(36'd0 - r_den) : r_den;
        w_num_mag  = r_num[49] ? 50'(50'd0 - r_num) : r_num;
    end

    logic [29:0] w_inc30, w_start30;
    assign w_inc30   = 30'(r_inc);
    assign w_start30 = 30'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_inc        <= 24'd167393;
            r_amp        <= 16'd13107;
            r_hc         <= 8'd4;
            r_low        <= 9'sd1;
            r_ratio      <= 16'sd410;
            r_acc_ph     <= '0;
            r_prev       <= Q24_ONE;
            r_rpow       <= '0;
            r_norm       <= '0;
            r_coef_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_dcnt       <= '0;
            r_ti         <= '0;
        end else begin
            if (o_out.valid && o_out.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_PHASE_INC:  r_inc <= i_cfg_data;
                    REG_AMPLITUDE:  r_amp <= i_cfg_data[15:0];
                    REG_HARM_COUNT: begin
                        r_hc         <= i_cfg_data[7:0];
                        r_coef_valid <= 1'b0;
                    end
                    REG_LOWEST:     r_low <= i_cfg_data[8:0];
                    REG_RATIO: begin
                        r_ratio      <= i_cfg_data[15:0];
                        r_coef_valid <= 1'b0;
                    end
                    REG_START:      r_acc_ph <= w_start30[PHASE_BITS-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_in.payload.kind == KIND_TICK) begin
                        r_ti <= '0;
                        if (!r_coef_valid) begin
                            r_ans   <= Q24_ONE;
                            r_x     <= {{4{r_ratio[15]}}, r_ratio, 12'd0};
                            r_e     <= w_n;
                            r_state <= S_PW;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_PW: begin
                    if (r_e == 8'd0) begin
                        r_state <= S_NRM;
                    end else if (r_e[0]) begin
                        r_ma    <= f_abs33(33'(r_ans));
                        r_mb    <= f_abs33(33'(r_x));
                        r_mneg  <= r_ans[31] ^ r_x[31];
                        r_ret   <= S_PW_A;
                        r_state <= S_MWAIT;
                    end else begin
                        r_state <= S_PW_X;
                    end
                end
                S_PW_A: begin
                    r_ans   <= w_rs24;
                    r_state <= S_PW_X;
                end
                S_PW_X: begin
                    r_ma    <= f_abs33(33'(r_x));
                    r_mb    <= f_abs33(33'(r_x));
                    r_mneg  <= 1'b0;
                    r_ret   <= S_PW_XR;
                    r_state <= S_MWAIT;
                end
                S_PW_XR: begin
                    r_x     <= w_rs24;
                    r_e     <= r_e >> 1;
                    r_state <= S_PW;
                end
                S_NRM: begin
                    r_rpow <= r_ans;
                    r_rem  <= '0;
                    r_dcnt <= '0;
                    r_ret  <= S_NRM_D;
                    if (w_near || w_nden == 33'sd0) begin
                        r_dvd  <= 64'h100_0000;
                        r_dvs  <= 36'(w_n);
                        r_dneg <= 1'b0;
                    end else begin
                        r_dvd  <= 64'(w_nnum_mag) << 36;
                        r_dvs  <= 36'(f_abs33(w_nden));
                        r_dneg <= w_nnum[17] ^ w_nden[32];
                    end
                    r_state <= S_DIV;
                end
                S_NRM_D: begin
                    r_norm       <= f_qsat(r_quo, r_dneg);
                    r_coef_valid <= 1'b1;
                    r_state      <= S_RD;
                end
                S_RD: begin
                    if (r_ti != 3'd0) begin
                        r_tv[r_ti - 3'd1] <= r_rdata;
                    end
                    if (r_ti == 3'd5) begin
                        r_ma    <= 33'(r_ratio);
                        r_mb    <= 33'(r_ratio);
                        r_ret   <= S_M1R;
                        r_state <= S_MWAIT;
                    end else begin
                        r_ti <= r_ti + 3'd1;
                    end
                end
                S_M1R: begin
                    r_den   <= (36'(r_prod) + 36'sd16777216) <<< 2;
                    r_ma    <= 33'(r_ratio);
                    r_mb    <= 33'(r_tv[0]);
                    r_ret   <= S_M2R;
                    r_state <= S_MWAIT;
                end
                S_M2R: begin
                    r_den   <= r_den - (36'(r_prod) <<< 1);
                    r_ma    <= 33'(r_ratio);
                    r_mb    <= 33'(r_tv[2]);
                    r_ret   <= S_M3R;
                    r_state <= S_MWAIT;
                end
                S_M3R: begin
                    r_num   <= (50'(r_tv[1]) <<< 24) - (50'(r_prod) <<< 12);
                    r_ma    <= 33'(r_rpow);
                    r_mb    <= 33'(r_tv[3]);
                    r_ret   <= S_M4R;
                    r_state <= S_MWAIT;
                end
                S_M4R: begin
                    r_num   <= r_num - 50'(r_prod);
                    r_ma    <= f_abs33(33'(r_rpow));
                    r_mb    <= f_abs33(33'(r_ratio));
                    r_mneg  <= r_rpow[31] ^ r_ratio[15];
                    r_ret   <= S_M5R;
                    r_state <= S_MWAIT;
                end
                S_M5R: begin
                    r_ma    <= 33'(w_rs12);
                    r_mb    <= 33'(r_tv[4]);
                    r_ret   <= S_M6R;
                    r_state <= S_MWAIT;
                end
                S_M6R: begin
                    r_num   <= r_num + 50'(r_prod);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_den_mag < DEN_SMALL) begin
                        r_state <= S_HOLD;
                    end else begin
                        r_dvd   <= 64'(w_num_mag) << 12;
                        r_dvs   <= w_den_mag;
                        r_dneg  <= r_num[49] ^ r_den[35];
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_ret   <= S_Q;
                        r_state <= S_DIV;
                    end
                end
                S_HOLD: begin
                    if (r_prev == S32_MIN) begin
                        r_res <= S32_MAX;
                    end else if (r_prev[31]) begin
                        r_res <= 32'(32'sd0 - r_prev);
                    end else begin
                        r_res <= r_prev;
                    end
                    r_state <= S_FIN;
                end
                S_Q: begin
                    r_qmag  <= r_quo;
                    r_qneg  <= r_dneg;
                    r_ma    <= 33'(r_amp);
                    r_mb    <= f_abs33(33'(r_norm));
                    r_mneg  <= r_norm[31];
                    r_ret   <= S_SC;
                    r_state <= S_MWAIT;
                end
                S_SC: begin
                    r_scal  <= w_rs15;
                    r_ma    <= {1'b0, r_qmag[31:0]};
                    r_mb    <= f_abs33(33'(w_rs15));
                    r_mneg  <= r_qneg ^ w_rs15[31];
                    r_ret   <= S_QL;
                    r_state <= S_MWAIT;
                end
                S_QL: begin
                    r_acc   <= 80'(r_prod);
                    r_ma    <= {1'b0, r_qmag[63:32]};
                    r_mb    <= f_abs33(33'(r_scal));
                    r_ret   <= S_QH;
                    r_state <= S_MWAIT;
                end
                S_QH: begin
                    r_acc   <= r_acc + (80'(r_prod) << 32);
                    r_state <= S_QR;
                end
                S_QR: begin
                    r_res   <= w_rsacc;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_sample    <= r_res;
                        r_out_valid <= 1'b1;
                        r_prev      <= r_res;
                        r_acc_ph    <= r_acc_ph + w_inc30[PHASE_BITS-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                S_MWAIT: begin
                    r_state <= r_ret;
                end
                S_DIV: begin
                    r_rem  <= w_ge ? 36'(w_rsh - {1'b0, r_dvs}) : w_rsh[35:0];
                    r_dvd  <= r_dvd << 1;
                    r_quo  <= {r_quo[62:0], w_ge};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) begin
                        r_state <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.payload.sample = r_sample;

    a_write_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && !r_out_valid) |=> !r_out_valid)
        else $error("table write produced a sample");

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> (r_dcnt == 6'd0))
        else $error("divider count left nonzero");

    a_coef_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> r_coef_valid)
        else $error("sample finished with stale coefficients");

    a_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> !w_wr_en)
        else $error("table read and write collide");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the band-limited pulse oscillator core.
//
// Every eighth cosine table entry is loaded first, and all phases are kept
// on that grid. Then come directed register settings and ticks (extremes,
// ratio near one, near-zero denominator hold), random register settings
// with mixed table writes and ticks under several idle/stall mixes, and a
// long output hold-off with a later pause until every sample has come back.
// A fixed-point predictor computes each expected sample, and a checker
// compares it with the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import bpo_pkg::*;

    localparam int DRAIN_CYCLES = 250;
    localparam bit [23:0] PHASE_GRID = 24'hFF8000;

    bit i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [23:0] i_cfg_data;

    bpo_stream_if #(.T(t_bpo_in))  in_if();
    bpo_stream_if #(.T(t_bpo_out)) out_if();

    bandlimited_pulse_oscillator_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    bit [23:0]   p_inc, p_start, p_phase;
    bit [15:0]   p_amp;
    bit [7:0]    p_count;
    int          p_lowest;
    longint      p_ratio;
    shortint     p_table [4096];
    int          p_prev, p_rpow, p_norm;
    bit          p_coef_ok;

    int          sample_q [$];
    int          errors = 0;
    int          idle_pct;
    int          stall_pct;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic int mul_round(longint a, longint b, int sh);
        bit neg;
        longint unsigned ma, mb, p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        if (mb != 0 && ma > (64'hFFFF_FFFF_FFFF_FFFF >> 2) / mb)
            return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        p = ma * mb;
        p = (p + (64'd1 << (sh - 1))) >> sh;
        if (p > (64'd1 << 31)) p = 64'd1 << 31;
        return neg ? sat32(-longint'(p)) : sat32(longint'(p));
    endfunction

    function automatic int harm_count();
        return (p_count == 0) ? 1 : int'(p_count);
    endfunction

    function automatic longint tab_at(bit [31:0] idx);
        return longint'(p_table[idx[11:0]]);
    endfunction

    function automatic void update_coefs();
        int n;
        longint x, ans, absr, den, num;
        int e;
        n = harm_count();
        x = p_ratio * 4096;
        ans = 64'sd1 << 24;
        absr = (p_ratio < 0) ? -p_ratio : p_ratio;
        e = n;
        while (e != 0) begin
            if (e & 1) ans = mul_round(ans, x, 24);
            e = e >> 1;
            x = mul_round(x, x, 24);
        end
        p_rpow = int'(ans);
        den = (64'sd1 << 24) - ((ans < 0) ? -ans : ans);
        if ((absr >= 4092 && absr <= 4100) || den == 0) begin
            p_norm = int'((64'sd1 << 24) / longint'(n));
        end else begin
            num = (4096 - absr) * 4096 * (64'sd1 << 24);
            p_norm = sat32(num / den);
        end
        p_coef_ok = 1'b1;
    endfunction

    function automatic void predict_item(t_bpo_in it);
        bit [31:0] k, km1, kpn, kpnm1, phs;
        longint t0, denom, num, rtn, rtnp1, q;
        int scal, res;
        if (it.kind == KIND_WRITE) begin
            p_table[it.table_index] = it.table_value;
            return;
        end
        if (!p_coef_ok) update_coefs();
        k = p_lowest;
        km1 = k - 1;
        kpn = k + harm_count();
        kpnm1 = kpn - 1;
        phs = {20'd0, p_phase[23:12]};
        t0 = tab_at(phs);
        denom = (p_ratio * p_ratio + (64'sd1 << 24)) * 4 - 2 * p_ratio * t0;
        rtn = p_rpow;
        rtnp1 = mul_round(rtn, p_ratio, 12);
        num = tab_at(phs * k) * (64'sd1 << 24)
            - p_ratio * tab_at(phs * km1) * 4096
            - rtn * tab_at(phs * kpn)
            + rtnp1 * tab_at(phs * kpnm1);
        if (denom >= 13422 || denom <= -13422) begin
            q = (num * 4096) / denom;
            scal = mul_round(longint'(p_amp), longint'(p_norm), 15);
            res = mul_round(q, longint'(scal), 24);
        end else if (p_prev < 0) begin
            res = sat32(-longint'(p_prev));
        end else begin
            res = p_prev;
        end
        p_prev = res;
        p_phase = p_phase + p_inc;
        sample_q.push_back(res);
    endfunction

    task automatic write_reg(t_reg_idx idx, bit [23:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_PHASE_INC:  p_inc = data;
            REG_AMPLITUDE:  p_amp = data[15:0];
            REG_HARM_COUNT: begin p_count = data[7:0]; p_coef_ok = 1'b0; end
            REG_LOWEST:     p_lowest = {{23{data[8]}}, data[8:0]};
            REG_RATIO:      begin p_ratio = {{48{data[15]}}, data[15:0]}; p_coef_ok = 1'b0; end
            REG_START:      begin p_start = data; p_phase = data; end
            default: ;
        endcase
    endtask

    task automatic send_item(t_bpo_in it);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_item(it);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_write(bit [11:0] idx, bit [15:0] val);
        t_bpo_in it;
        it.kind = KIND_WRITE;
        it.table_index = idx;
        it.table_value = val;
        send_item(it);
    endtask

    task automatic send_tick();
        t_bpo_in it;
        it = t_bpo_in'(29'($urandom));
        it.kind = KIND_TICK;
        send_item(it);
    endtask

    task automatic send_random();
        t_bpo_in it;
        it = t_bpo_in'(29'($urandom));
        it.kind = ($urandom_range(3) == 0) ? KIND_WRITE : KIND_TICK;
        send_item(it);
    endtask

    task automatic test_table_load();
        real c;
        for (int i = 0; i < 4096; i += 8) begin
            c = $cos(6.283185307179586 * i / 4096.0) * 16384.0;
            send_write(i[11:0], 16'(int'(c)));
        end
        wait_idle();
    endtask

    task automatic test_directed();
        // ratio of one with a full-scale table word: denominator vanishes
        write_reg(REG_PHASE_INC, 24'd0);
        write_reg(REG_START, 24'd0);
        write_reg(REG_RATIO, 24'd4096);
        write_reg(REG_HARM_COUNT, 24'd1);
        write_reg(REG_AMPLITUDE, 24'hFFFF);
        send_write(12'd0, 16'sd16384);
        send_tick();
        send_tick();
        send_write(12'd0, -16'sd16384);
        send_tick();
        send_write(12'd0, 16'sd16384);
        send_tick();
        wait_idle();
        write_reg(REG_PHASE_INC, PHASE_GRID);
        write_reg(REG_HARM_COUNT, 24'd0);
        write_reg(REG_LOWEST, 24'h1FF & -24'd255);
        write_reg(REG_RATIO, 24'hFFFF & -24'd32768);
        write_reg(REG_AMPLITUDE, 24'd0);
        send_tick();
        send_tick();
        wait_idle();
        write_reg(REG_HARM_COUNT, 24'd255);
        write_reg(REG_LOWEST, 24'd255);
        write_reg(REG_RATIO, 24'd32767);
        write_reg(REG_AMPLITUDE, 24'hFFFF);
        write_reg(REG_START, PHASE_GRID);
        send_tick();
        send_tick();
        wait_idle();
        write_reg(REG_RATIO, 24'hFFFF & -24'd4096);
        write_reg(REG_HARM_COUNT, 24'd7);
        send_tick();
        wait_idle();
        write_reg(REG_RATIO, 24'd0);
        send_tick();
        send_tick();
        wait_idle();
        write_reg(REG_START, 24'd0);
        write_reg(REG_PHASE_INC, 24'd167393);
        send_write(12'd0, 16'd16384);
        wait_idle();
    endtask

    task automatic random_config();
        bit [15:0] r;
        case ($urandom_range(3))
            0: r = 16'(4092 + $urandom_range(8));
            1: r = -16'(4092 + $urandom_range(8));
            2: r = 16'($urandom_range(8191)) - 16'd4096;
            default: r = 16'($urandom);
        endcase
        write_reg(REG_PHASE_INC, PHASE_GRID & (($urandom_range(1) == 1)
                                 ? 24'($urandom) : 24'($urandom_range(400000))));
        write_reg(REG_AMPLITUDE, 24'($urandom_range(65535)));
        write_reg(REG_HARM_COUNT, 24'($urandom_range(255)));
        write_reg(REG_LOWEST, 24'($urandom_range(511)));
        write_reg(REG_RATIO, {8'd0, r});
        write_reg(REG_START, PHASE_GRID & 24'($urandom));
    endtask

    task automatic test_random_phases();
        int idles [4] = '{0, 55, 0, 9};
        int stalls [4] = '{0, 0, 55, 9};
        for (int ph = 0; ph < 8; ph++) begin
            idle_pct = idles[ph % 4];
            stall_pct = stalls[ph % 4];
            random_config();
            repeat (104) send_random();
            wait_idle();
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_pressure();
        random_config();
        @(posedge i_clk);
        hold_req++;
        repeat (20) send_tick();
        repeat (40) send_random();
        wait_idle();
        repeat (30) send_random();
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 1500;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        int want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (sample_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected sample %0d", out_if.payload.sample);
            end else begin
                want = sample_q.pop_front();
                if (out_if.payload.sample !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("sample mismatch: expected %0d actual %0d",
                                 want, out_if.payload.sample);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_PHASE_INC;
        i_cfg_data = 24'd0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        idle_pct = 0;
        stall_pct = 0;
        p_inc = 24'd167393;
        p_amp = 16'd13107;
        p_count = 8'd4;
        p_lowest = 1;
        p_ratio = 410;
        p_start = 24'd0;
        p_phase = 24'd0;
        p_prev = 32'sh0100_0000;
        p_rpow = 0;
        p_norm = 0;
        p_coef_ok = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_table_load();
        test_directed();
        test_random_phases();
        test_pressure();
        if (errors == 0 && sample_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
